[rtl/erca_pkg.sv]
// erca_pkg: shared types and constants of the encoder calibration and angle block
// no dependencies
`default_nettype none

package erca_pkg;

  // field widths fixed by the item format
  localparam int MODE_W  = 3;
  localparam int TPR_W   = 18;
  localparam int ANGLE_W = 25;
  localparam int STAT_W  = 2;

  // request modes
  localparam logic [MODE_W-1:0] MODE_START  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_FINISH = 3'd1;
  localparam logic [MODE_W-1:0] MODE_ZERO   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_ANGLE  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_BOTH   = 3'd4;
  localparam logic [MODE_W-1:0] MODE_POS    = 3'd5;
  localparam logic [MODE_W-1:0] MODE_NEG    = 3'd6;

  // result status codes
  localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_BOUNDS  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NO_CAPT = 2'd2;

  // accepted ticks-per-revolution window
  localparam logic [TPR_W-1:0] TPR_MIN = 18'd10;
  localparam logic [TPR_W-1:0] TPR_MAX = 18'd200000;

  // update request from the sequencer to the calibration store
  typedef struct packed {
    logic              upd;
    logic [MODE_W-1:0] mode;
    logic [TPR_W-1:0]  tpr_value;
  } calib_req_t;

  // calibration state seen by the sequencer
  typedef struct packed {
    logic [TPR_W-1:0] tpr_pos;
    logic [TPR_W-1:0] tpr_neg;
    logic             calibrated;
    logic             capturing;
  } calib_state_t;

endpackage

`default_nettype wire

[rtl/erca_serdiv.sv]
// erca_serdiv: bit-serial restoring divider, one dividend bit per cycle while step is high, msb first
// depends on erca_pkg
`default_nettype none

module erca_serdiv
  import erca_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             clr,
  input  wire logic             step,
  input  wire logic             din,
  input  wire logic [TPR_W-1:0] divisor,
  output logic      [TPR_W-1:0] rem,
  output logic                  qbit
);

  logic [TPR_W-1:0] rem_r;
  logic [TPR_W-1:0] rem_nxt;
  logic [TPR_W:0]   trial;
  logic [TPR_W:0]   diff;

  // shift in one bit and try the subtraction
  always_comb begin
    trial = {rem_r, din};
    diff  = trial - {1'b0, divisor};
    qbit  = (trial >= {1'b0, divisor});
    if (clr) begin
      rem_nxt = '0;
    end else if (step) begin
      rem_nxt = qbit ? diff[TPR_W-1:0] : trial[TPR_W-1:0];
    end else begin
      rem_nxt = rem_r;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
  end

  assign rem = rem_r;

endmodule

`default_nettype wire

[rtl/erca_calib.sv]
// erca_calib: calibration store (ticks per revolution, capture, zero tick) and checks
// depends on erca_pkg
`default_nettype none

module erca_calib
  import erca_pkg::*;
#(
  parameter int TICK_BITS = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire calib_req_t           req,
  input  wire logic [TICK_BITS-1:0] ticks,
  output calib_state_t              st,
  output logic      [TICK_BITS-1:0] zero_ticks,
  output logic      [STAT_W-1:0]    status
);

  localparam int EW = (TICK_BITS > TPR_W) ? TICK_BITS : TPR_W;

  logic [TPR_W-1:0]     tpr_pos_r, tpr_pos_nxt;
  logic [TPR_W-1:0]     tpr_neg_r, tpr_neg_nxt;
  logic                 cal_r, cal_nxt;
  logic                 capt_r, capt_nxt;
  logic [TICK_BITS-1:0] start_r, start_nxt;
  logic [TICK_BITS-1:0] zero_r, zero_nxt;
  logic [TICK_BITS-1:0] span;
  logic [EW-1:0]        span_x;
  logic                 span_ok;
  logic                 val_ok;

  // captured span and manual value checks
  always_comb begin
    span    = ticks - start_r;
    span_x  = EW'(span);
    span_ok = !span[TICK_BITS-1] && (span_x >= EW'(TPR_MIN)) && (span_x <= EW'(TPR_MAX));
    val_ok  = (req.tpr_value >= TPR_MIN) && (req.tpr_value <= TPR_MAX);
  end

  // state update per request
  always_comb begin
    tpr_pos_nxt = tpr_pos_r;
    tpr_neg_nxt = tpr_neg_r;
    cal_nxt     = cal_r;
    capt_nxt    = capt_r;
    start_nxt   = start_r;
    zero_nxt    = zero_r;
    status      = STAT_OK;
    unique case (req.mode)
      MODE_START: begin
        capt_nxt  = 1'b1;
        start_nxt = ticks;
      end
      MODE_FINISH: begin
        if (!capt_r) begin
          status = STAT_NO_CAPT;
        end else begin
          capt_nxt = 1'b0;
          if (!span_ok) begin
            status = STAT_BOUNDS;
          end else begin
            cal_nxt     = 1'b1;
            tpr_pos_nxt = span_x[TPR_W-1:0];
            tpr_neg_nxt = span_x[TPR_W-1:0];
          end
        end
      end
      MODE_ZERO: begin
        zero_nxt = ticks;
      end
      MODE_BOTH, MODE_POS, MODE_NEG: begin
        if (!val_ok) begin
          status = STAT_BOUNDS;
        end else begin
          capt_nxt    = 1'b0;
          cal_nxt     = 1'b1;
          tpr_pos_nxt = req.tpr_value;
          tpr_neg_nxt = req.tpr_value;
          if (req.mode == MODE_POS && tpr_neg_r != '0) begin
            tpr_neg_nxt = tpr_neg_r;
          end
          if (req.mode == MODE_NEG && tpr_pos_r != '0) begin
            tpr_pos_nxt = tpr_pos_r;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tpr_pos_r <= '0;
      tpr_neg_r <= '0;
      cal_r     <= 1'b0;
      capt_r    <= 1'b0;
      start_r   <= '0;
      zero_r    <= '0;
    end else if (req.upd) begin
      tpr_pos_r <= tpr_pos_nxt;
      tpr_neg_r <= tpr_neg_nxt;
      cal_r     <= cal_nxt;
      capt_r    <= capt_nxt;
      start_r   <= start_nxt;
      zero_r    <= zero_nxt;
    end
  end

  assign st.tpr_pos    = tpr_pos_r;
  assign st.tpr_neg    = tpr_neg_r;
  assign st.calibrated = cal_r;
  assign st.capturing  = capt_r;
  assign zero_ticks    = zero_r;

endmodule

`default_nettype wire

[rtl/encoder_rev_calibration_angle.sv]
// encoder_rev_calibration_angle: top level, request sequencer, serial angle datapath
// depends on erca_pkg, erca_calib, erca_serdiv
`default_nettype none

// Keeps a turret encoder calibration (ticks per revolution for each direction, a zero
// tick) and answers angle queries. One request is worked at a time; in_tready is high
// while the sequencer is idle, also while a finished result still waits on the output
// register. An angle query on a calibrated block runs the shared bit-serial divider
// twice: it first reduces the tick distance modulo tpr_pos, then divides
// remainder * 360 * 2^ANGLE_FRAC_BITS by tpr_pos. Results carry the calibration
// state after the request; the angle is masked to 25 bits.
module encoder_rev_calibration_angle
  import erca_pkg::*;
#(
  parameter int  TICK_BITS       = 32,
  parameter int  ANGLE_FRAC_BITS = 16,
  localparam int IN_DW           = ((TICK_BITS + TPR_W + 7) / 8) * 8,
  localparam int OUT_RAW         = STAT_W + ANGLE_W + 2 * TPR_W + 2,
  localparam int OUT_DW          = ((OUT_RAW + 7) / 8) * 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // [TICK_BITS-1:0] ticks, [TICK_BITS+17:TICK_BITS] tpr_value, zero fill above
  input  wire logic [IN_DW-1:0]      in_tdata,
  // [2:0] mode
  input  wire logic [MODE_W-1:0]     in_tuser,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // [1:0] status, [26:2] angle_q16, [44:27] tpr_pos_now, [62:45] tpr_neg_now,
  // [63] is_calibrated, [64] is_capturing, zero fill above
  output logic [OUT_DW-1:0]          out_tdata
);

  localparam int R360_W  = TPR_W + 9;
  localparam int NUM_W   = R360_W + ANGLE_FRAC_BITS;
  localparam int QW      = 9 + ANGLE_FRAC_BITS;
  localparam int AQW     = (QW > ANGLE_W) ? QW : ANGLE_W;
  localparam int CMAX    = (TICK_BITS > NUM_W) ? TICK_BITS : NUM_W;
  localparam int CNT_W   = $clog2(CMAX + 1);

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_MOD  = 3'd2;
  localparam logic [2:0] S_FIX  = 3'd3;
  localparam logic [2:0] S_MUL  = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0]            state_r, state_nxt;
  logic [CNT_W-1:0]      cnt_r;
  logic [MODE_W-1:0]     mode_r;
  logic [TICK_BITS-1:0]  ticks_r;
  logic [TPR_W-1:0]      tval_r;
  logic [STAT_W-1:0]     status_r;
  logic [TICK_BITS-1:0]  mag_r;
  logic                  neg_r;
  logic [TPR_W-1:0]      rfix_r;
  logic [NUM_W-1:0]      num_r;
  logic [QW-1:0]         q_r;
  logic                  out_vld_r;
  logic [OUT_DW-1:0]     out_data_r;

  calib_req_t            creq;
  calib_state_t          cst;
  logic [TICK_BITS-1:0]  zero_ticks;
  logic [STAT_W-1:0]     cstatus;
  logic [TICK_BITS-1:0]  tick_dist;
  logic [TICK_BITS-1:0]  dist_mag;
  logic                  angle_go;
  logic [TPR_W-1:0]      rem;
  logic                  qbit;
  logic                  div_din;
  logic [R360_W-1:0]     r27;
  logic [R360_W-1:0]     r360;
  logic [AQW-1:0]        q_ext;
  logic                  out_free;
  logic                  in_acc;

  // calibration store
  assign creq.upd       = (state_r == S_EXEC);
  assign creq.mode      = mode_r;
  assign creq.tpr_value = tval_r;

  erca_calib #(
    .TICK_BITS (TICK_BITS)
  ) u_calib (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (creq),
    .ticks      (ticks_r),
    .st         (cst),
    .zero_ticks (zero_ticks),
    .status     (cstatus)
  );

  // shared serial divider, fed from the modulo or the numerator shifter
  assign div_din = (state_r == S_MOD) ? mag_r[TICK_BITS-1] : num_r[NUM_W-1];

  erca_serdiv u_div (
    .clk     (clk),
    .clr     ((state_r == S_EXEC) || (state_r == S_MUL)),
    .step    ((state_r == S_MOD) || (state_r == S_DIV)),
    .din     (div_din),
    .divisor (cst.tpr_pos),
    .rem     (rem),
    .qbit    (qbit)
  );

  // tick distance from zero and its magnitude
  always_comb begin
    tick_dist = ticks_r - zero_ticks;
    dist_mag  = tick_dist[TICK_BITS-1] ? (~tick_dist + TICK_BITS'(1)) : tick_dist;
    angle_go  = (mode_r == MODE_ANGLE) && cst.calibrated && (cst.tpr_pos != '0);
  end

  // remainder times 360 as shifted adds
  always_comb begin
    r27  = R360_W'(rfix_r);
    r360 = (r27 << 8) + (r27 << 6) + (r27 << 5) + (r27 << 3);
  end

  assign out_free = !out_vld_r || out_tready;
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_acc) state_nxt = S_EXEC;
      S_EXEC: state_nxt = angle_go ? S_MOD : S_DONE;
      S_MOD:  if (cnt_r == '0) state_nxt = S_FIX;
      S_FIX:  state_nxt = S_MUL;
      S_MUL:  state_nxt = S_DIV;
      S_DIV:  if (cnt_r == '0) state_nxt = S_DONE;
      S_DONE: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // request capture and serial datapath
  always_ff @(posedge clk) begin
    if (in_acc) begin
      mode_r  <= in_tuser;
      ticks_r <= in_tdata[TICK_BITS-1:0];
      tval_r  <= in_tdata[TICK_BITS+TPR_W-1:TICK_BITS];
    end
    unique case (state_r)
      S_EXEC: begin
        status_r <= cstatus;
        q_r      <= '0;
        mag_r    <= dist_mag;
        neg_r    <= tick_dist[TICK_BITS-1];
        cnt_r    <= CNT_W'(TICK_BITS - 1);
      end
      S_MOD: begin
        mag_r <= {mag_r[TICK_BITS-2:0], 1'b0};
        cnt_r <= cnt_r - CNT_W'(1);
      end
      S_FIX: begin
        rfix_r <= (neg_r && rem != '0) ? (cst.tpr_pos - rem) : rem;
      end
      S_MUL: begin
        num_r <= {r360, {ANGLE_FRAC_BITS{1'b0}}};
        cnt_r <= CNT_W'(NUM_W - 1);
      end
      S_DIV: begin
        num_r <= {num_r[NUM_W-2:0], 1'b0};
        q_r   <= {q_r[QW-2:0], qbit};
        cnt_r <= cnt_r - CNT_W'(1);
      end
      default: begin
      end
    endcase
  end

  // output register
  assign q_ext = AQW'(q_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (state_r == S_DONE && out_free) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_DONE && out_free) begin
      out_data_r <= OUT_DW'({cst.capturing, cst.calibrated, cst.tpr_neg, cst.tpr_pos,
                             q_ext[ANGLE_W-1:0], status_r});
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  // a held calibration stays within the accepted window
  a_cal_range: assert property (@(posedge clk) disable iff (!rst_n)
    cst.calibrated |-> (cst.tpr_pos >= TPR_MIN && cst.tpr_pos <= TPR_MAX &&
                        cst.tpr_neg >= TPR_MIN && cst.tpr_neg <= TPR_MAX))
    else $error("calibration outside window");

  // divider remainder stays below the divisor while it iterates
  a_rem_below: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MOD || state_r == S_FIX || state_r == S_DIV) |-> (rem < cst.tpr_pos))
    else $error("divider remainder not reduced");

  // a nonzero angle only comes from a calibrated block
  a_angle_cal: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (out_data_r[STAT_W+ANGLE_W-1:STAT_W] == '0 ||
                   out_data_r[STAT_W+ANGLE_W+2*TPR_W]))
    else $error("angle from uncalibrated block");

  // no input taken while a request is being worked
  a_one_at_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == S_EXEC && !in_tready))
    else $error("request overlap");

  // status code is always a defined one
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (out_data_r[STAT_W-1:0] == STAT_OK ||
                   out_data_r[STAT_W-1:0] == STAT_BOUNDS ||
                   out_data_r[STAT_W-1:0] == STAT_NO_CAPT))
    else $error("undefined status");

endmodule

`default_nettype wire
